### design/srr_pkg.sv
// Shared types and constants for the systematic resampling replication block.
`default_nettype none

package srr_pkg;

    localparam int WEIGHT_W = 16;
    localparam int COUNT_W  = 13;
    localparam int PCOUNT_W = 13;
    localparam int WSUM_W   = 28;
    localparam int OFFSET_W = 16;
    localparam int PROD_W   = PCOUNT_W + WEIGHT_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = WSUM_W;
    localparam int COUNT_FIELD_MAX = (1 << COUNT_W) - 1;

    localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = PCOUNT_W'(1024);
    localparam logic [WSUM_W-1:0]   WSUM_RESET   = WSUM_W'(1);
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = '0;

    localparam logic [CFG_IDX_W-1:0] CFG_PARTICLE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_SUM     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET   = 2'd2;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic                last_weight;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] replication_count;
        logic               last_count;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load_in;   // capture input transfer
        logic mul;       // multiply and seed the divider
        logic div_step;  // one restoring-division bit
        logic sub;       // subtract residual from scaled weight
        logic fin;       // form count, update residual, load output register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_busy;  // output register holds a result not taken this cycle
    } dp_status_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_SUB  = 5'b01000,
        ST_FIN  = 5'b10000
    } ctrl_state_t;

endpackage

`default_nettype wire

### design/systematic_resampling_replication.sv
// Top level: systematic resampling replication-count stage.
//
// Usage:
//   in channel  (in_valid/in_ready/in_data): one weight per transfer, last_weight
//     marks the final weight of a run; the next weight restarts the residual
//     from start_offset.
//   out channel (out_valid/out_ready/out_data): one replication count per weight,
//     in order, last_count copied from last_weight.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 particle_count,
//     1 weight_sum, 2 start_offset; other indexes ignored. cfg_ready is always
//     high; write only while no weight is in flight.
// Flow: each weight passes multiply, a bit-per-cycle restoring divider over the
//   29+FRAC_BITS quotient bits, subtract and finish; the result is then registered
//   in the output register, and no new weight is taken before that.
// The next weight is accepted while a result waits in the output register; if
//   the receiver still stalls when the following result is ready, the block
//   holds it internally and stops taking input.
// Reset: config registers return to 1024 / 1 / 0, residual clears, a new run
//   begins, the output register empties.
`default_nettype none

module systematic_resampling_replication #(
    parameter int FRAC_BITS    = 16,
    parameter int PARTICLE_MAX = 4096
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire srr_pkg::in_item_t              in_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output srr_pkg::out_item_t                  out_data,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [srr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [srr_pkg::CFG_DATA_W-1:0] cfg_data
);

    srr_pkg::dp_cmd_t    cmd;
    srr_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    srr_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    srr_datapath #(
        .FRAC_BITS    (FRAC_BITS),
        .PARTICLE_MAX (PARTICLE_MAX)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

### design/srr_ctrl.sv
// Controller state machine: sequences multiply, division, subtract and output.
`default_nettype none

module srr_ctrl #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire srr_pkg::dp_status_t status,
    output srr_pkg::dp_cmd_t        cmd
);

    localparam int QW  = srr_pkg::PROD_W + FRAC_BITS;
    localparam int CNT_W = $clog2(QW);

    srr_pkg::ctrl_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srr_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            srr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = srr_pkg::ST_MUL;
                end
            end
            srr_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                cnt_next   = '0;
                state_next = srr_pkg::ST_DIV;
            end
            srr_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(QW - 1))
                begin
                    state_next = srr_pkg::ST_SUB;
                end
            end
            srr_pkg::ST_SUB:
            begin
                cmd.sub    = 1'b1;
                state_next = srr_pkg::ST_FIN;
            end
            srr_pkg::ST_FIN:
            begin
                // hold until the output register is free
                if (!status.out_busy)
                begin
                    cmd.fin    = 1'b1;
                    state_next = srr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = srr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/srr_datapath.sv
// Datapath: config registers, multiplier, restoring divider, residual recurrence, output register.
`default_nettype none

module srr_datapath #(
    parameter int FRAC_BITS    = 16,
    parameter int PARTICLE_MAX = 4096
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire srr_pkg::in_item_t                   in_data,
    input  wire logic                                cfg_valid,
    input  wire logic [srr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [srr_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                out_ready,
    output logic                                     out_valid,
    output srr_pkg::out_item_t                       out_data,
    input  wire srr_pkg::dp_cmd_t                    cmd,
    output srr_pkg::dp_status_t                      status
);

    localparam int PW  = srr_pkg::PROD_W;
    localparam int QW  = PW + FRAC_BITS;
    localparam int RW  = FRAC_BITS + 1;
    localparam int DW  = srr_pkg::WSUM_W;
    localparam int CAP = (PARTICLE_MAX > srr_pkg::COUNT_FIELD_MAX) ?
                         srr_pkg::COUNT_FIELD_MAX : PARTICLE_MAX;

    // configuration
    logic [srr_pkg::PCOUNT_W-1:0] pcount_reg;
    logic [DW-1:0]                wsum_reg;
    logic [srr_pkg::OFFSET_W-1:0] offset_reg;

    // control state
    logic          run_start_reg;
    logic [RW-1:0] residual_reg, residual_next;
    logic          out_valid_reg;

    // payload
    logic [srr_pkg::WEIGHT_W-1:0] weight_reg;
    logic                         last_reg;
    logic [QW-1:0]                dq_reg;
    logic [DW-1:0]                rem_reg;
    logic [QW-1:0]                d_reg;
    logic [RW-1:0]                lo_reg;
    logic                         gt_reg;
    srr_pkg::out_item_t           out_reg;

    logic [DW-1:0]         divisor;
    logic [DW:0]           trial;
    logic [DW+1:0]         diff;
    logic                  qbit;
    logic [PW-1:0]         product;
    logic [srr_pkg::OFFSET_W+FRAC_BITS-1:0] offset_wide;
    logic [RW-1:0]         base;
    logic [PW-1:0]         whole;
    logic [srr_pkg::COUNT_W-1:0] count;

    assign divisor = (wsum_reg == '0) ? DW'(1) : wsum_reg;
    assign product = PW'(pcount_reg) * PW'(weight_reg);

    // restoring division step: remainder shifted with next dividend bit
    assign trial = {rem_reg, dq_reg[QW-1]};
    assign diff  = {1'b0, trial} - {2'b00, divisor};
    assign qbit  = ~diff[DW+1];

    // offset aligned from Q0.16 to FRAC_BITS fraction bits, truncated
    assign offset_wide = {offset_reg, {FRAC_BITS{1'b0}}};
    assign base = run_start_reg ?
                  RW'(offset_wide[srr_pkg::OFFSET_W+FRAC_BITS-1:srr_pkg::OFFSET_W]) :
                  residual_reg;

    // no copies unless the scaled weight exceeds the residual
    assign whole = d_reg[QW-1:FRAC_BITS];
    assign count = !gt_reg ? '0 :
                   (whole >= PW'(CAP)) ? srr_pkg::COUNT_W'(CAP) :
                   srr_pkg::COUNT_W'(whole + PW'(1));

    always_comb
    begin
        if (gt_reg)
        begin
            residual_next = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, d_reg[FRAC_BITS-1:0]};
        end
        else
        begin
            residual_next = lo_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcount_reg    <= srr_pkg::PCOUNT_RESET;
            wsum_reg      <= srr_pkg::WSUM_RESET;
            offset_reg    <= srr_pkg::OFFSET_RESET;
            run_start_reg <= 1'b1;
            residual_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    srr_pkg::CFG_PARTICLE_COUNT:
                        pcount_reg <= cfg_data[srr_pkg::PCOUNT_W-1:0];
                    srr_pkg::CFG_WEIGHT_SUM:
                        wsum_reg <= cfg_data;
                    srr_pkg::CFG_START_OFFSET:
                        offset_reg <= cfg_data[srr_pkg::OFFSET_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.fin)
            begin
                residual_reg  <= residual_next;
                run_start_reg <= last_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            weight_reg <= in_data.weight;
            last_reg   <= in_data.last_weight;
        end
        if (cmd.mul)
        begin
            dq_reg  <= {product, {FRAC_BITS{1'b0}}};
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dq_reg  <= {dq_reg[QW-2:0], qbit};
            rem_reg <= qbit ? diff[DW-1:0] : trial[DW-1:0];
        end
        if (cmd.sub)
        begin
            gt_reg <= dq_reg > QW'(base);
            d_reg  <= dq_reg - QW'(base);
            lo_reg <= base - dq_reg[RW-1:0];
        end
        if (cmd.fin)
        begin
            out_reg.replication_count <= count;
            out_reg.last_count        <= last_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_data        = out_reg;
    assign status.out_busy = out_valid_reg & ~out_ready;

endmodule

`default_nettype wire

### dv/systematic_resampling_replication_tb.sv
// Testbench for systematic_resampling_replication: random weight streams checked against a count predictor.
module systematic_resampling_replication_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS     = 16;
    localparam int PARTICLE_MAX  = 4096;
    localparam int COUNT_CAP     = (PARTICLE_MAX < srr_pkg::COUNT_FIELD_MAX) ? PARTICLE_MAX
                                                                     : srr_pkg::COUNT_FIELD_MAX;
    localparam int SETTLE_CYCLES = 29 + FRAC_BITS + 15;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 1125;

    class count_scoreboard;
        logic [srr_pkg::PCOUNT_W-1:0]  particles;
        logic [srr_pkg::WSUM_W-1:0]    wsum;
        logic [srr_pkg::OFFSET_W-1:0]  offset;
        logic [FRAC_BITS:0]            residual;
        bit                            run_start;
        srr_pkg::out_item_t            expected_counts[$];
        int                            errors;

        function new();
            particles = srr_pkg::PCOUNT_RESET;
            wsum      = srr_pkg::WSUM_RESET;
            offset    = srr_pkg::OFFSET_RESET;
            residual  = '0;
            run_start = 1'b1;
            errors    = 0;
        endfunction

        function void write_reg(logic [srr_pkg::CFG_IDX_W-1:0] idx,
                                logic [srr_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                srr_pkg::CFG_PARTICLE_COUNT: particles = data[srr_pkg::PCOUNT_W-1:0];
                srr_pkg::CFG_WEIGHT_SUM:     wsum      = data[srr_pkg::WSUM_W-1:0];
                srr_pkg::CFG_START_OFFSET:   offset    = data[srr_pkg::OFFSET_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_weight(srr_pkg::in_item_t item);
            logic [63:0] divisor;
            logic [63:0] scaled;
            logic [63:0] diff;
            logic [63:0] whole;
            srr_pkg::out_item_t exp_item;
            if (run_start) begin
                // offset is Q0.16, align to the residual's fraction width
                if (FRAC_BITS >= 16)
                    residual = (FRAC_BITS+1)'(64'(offset) << (FRAC_BITS - 16));
                else
                    residual = (FRAC_BITS+1)'(64'(offset) >> (16 - FRAC_BITS));
                run_start = 1'b0;
            end
            divisor = (wsum == '0) ? 64'd1 : 64'(wsum);
            scaled  = ((64'(particles) * 64'(item.weight)) << FRAC_BITS) / divisor;
            if (scaled > 64'(residual)) begin
                diff  = scaled - 64'(residual);
                whole = diff >> FRAC_BITS;
                exp_item.replication_count = (whole >= COUNT_CAP) ?
                                             srr_pkg::COUNT_W'(COUNT_CAP) :
                                             srr_pkg::COUNT_W'(whole + 1);
                residual = (FRAC_BITS+1)'((64'd1 << FRAC_BITS) -
                                          (diff & ((64'd1 << FRAC_BITS) - 1)));
            end else begin
                exp_item.replication_count = '0;
                residual = residual - scaled[FRAC_BITS:0];
            end
            exp_item.last_count = item.last_weight;
            if (item.last_weight)
                run_start = 1'b1;
            expected_counts.push_back(exp_item);
        endfunction

        function void check_count(srr_pkg::out_item_t got);
            srr_pkg::out_item_t exp_item;
            if (expected_counts.size() == 0) begin
                $error("unexpected count transfer: replication_count %0d last_count %0d",
                       got.replication_count, got.last_count);
                errors++;
                return;
            end
            exp_item = expected_counts.pop_front();
            if (got.replication_count !== exp_item.replication_count) begin
                $error("replication_count: expected %0d, got %0d",
                       exp_item.replication_count, got.replication_count);
                errors++;
            end
            if (got.last_count !== exp_item.last_count) begin
                $error("last_count: expected %0d, got %0d",
                       exp_item.last_count, got.last_count);
                errors++;
            end
        endfunction

        function int pending();
            return expected_counts.size();
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    srr_pkg::in_item_t              in_data = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    srr_pkg::out_item_t             out_data;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [srr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [srr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    count_scoreboard sb = new();
    bit calm = 1'b0;        // no idling on either side while set
    int rx_hold_req = 0;    // receiver hold-off request, in cycles

    systematic_resampling_replication #(
        .FRAC_BITS    (FRAC_BITS),
        .PARTICLE_MAX (PARTICLE_MAX)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // result side: check each transfer, then pick next ready
    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_count(out_data);
            if (!rst_n)
                out_ready <= 1'b0;
            else if (hold > 0) begin
                hold--;
                out_ready <= 1'b0;
            end else if (rx_hold_req > 0) begin
                hold = rx_hold_req - 1;
                rx_hold_req = 0;
                out_ready <= 1'b0;
            end else
                out_ready <= calm || ($urandom_range(99) >= 15);
        end
    end

    // ends the run when no transfer of any kind happens for too long
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("** systematic_resampling_replication: FAILED **");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [srr_pkg::CFG_IDX_W-1:0] idx,
                             logic [srr_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_regs(int unsigned pc, int unsigned ws, int unsigned off);
        write_reg(srr_pkg::CFG_PARTICLE_COUNT, srr_pkg::CFG_DATA_W'(pc));
        write_reg(srr_pkg::CFG_WEIGHT_SUM, srr_pkg::CFG_DATA_W'(ws));
        write_reg(srr_pkg::CFG_START_OFFSET, srr_pkg::CFG_DATA_W'(off));
    endtask

    task automatic send_weight(logic [srr_pkg::WEIGHT_W-1:0] w, logic last);
        srr_pkg::in_item_t item;
        item.weight      = w;
        item.last_weight = last;
        if (!calm && $urandom_range(99) < 15) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_weight(item);
    endtask

    // drop valid and wait until every count has come back, plus some slack
    task automatic settle(int extra);
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    initial
    begin
        int sent;
        int phase;
        int n_items;
        int run_len;
        int run_pos;
        int unsigned pc;
        int unsigned ws;
        int unsigned off;
        int unsigned wmax;
        int unsigned pick;
        logic [srr_pkg::WEIGHT_W-1:0] w;
        logic last;

        @(posedge clk);
        while (!rst_n) @(posedge clk);

        // reset values: with weight_sum of 1 a full-scale weight saturates the count
        send_weight(16'd0, 1'b0);
        send_weight(16'd1, 1'b0);
        send_weight(16'hFFFF, 1'b0);
        send_weight(16'd0, 1'b1);
        settle(SETTLE_CYCLES);

        write_reg(2'd3, '1);    // unmapped index, must be ignored
        program_regs(4096, 16 * 65535, 32768);
        send_weight(16'hFFFF, 1'b0);
        send_weight(16'd0, 1'b0);
        send_weight(16'd1, 1'b0);
        send_weight(16'hAAAA, 1'b0);
        send_weight(16'h5555, 1'b0);
        send_weight(16'h8000, 1'b1);
        settle(SETTLE_CYCLES);

        // zero divisor acts as one; then zero particles
        program_regs(8191, 0, 65535);
        send_weight(16'hFFFF, 1'b0);
        send_weight(16'd1, 1'b0);
        send_weight(16'd0, 1'b1);
        settle(SETTLE_CYCLES);
        write_reg(srr_pkg::CFG_PARTICLE_COUNT, '0);
        send_weight(16'hFFFF, 1'b0);
        send_weight(16'd12345, 1'b1);
        settle(SETTLE_CYCLES);

        // scaled equals weight: hits scaled == residual exactly
        program_regs(1, 65536, 65535);
        send_weight(16'hFFFF, 1'b0);
        send_weight(16'd0, 1'b0);
        send_weight(16'd1, 1'b0);
        send_weight(16'd2, 1'b0);
        settle(SETTLE_CYCLES);
        // offset change mid-run only applies from the next run on
        write_reg(srr_pkg::CFG_START_OFFSET, '0);
        send_weight(16'd1000, 1'b0);
        send_weight(16'd7, 1'b1);
        send_weight(16'd500, 1'b0);
        send_weight(16'd9, 1'b1);
        settle(SETTLE_CYCLES);

        program_regs(4096, 28'hFFFFFFF, 0);
        send_weight(16'hFFFF, 1'b0);
        send_weight(16'hFFFF, 1'b1);
        settle(SETTLE_CYCLES);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(9) == 0) begin
                pick = $urandom_range(3);
                pc   = (pick == 0) ? 0 : (pick == 1) ? 1 : (pick == 2) ? 4096 : 8191;
                pick = $urandom_range(3);
                ws   = (pick == 0) ? 0 : (pick == 1) ? 1 : (pick == 2) ? 28'hFFFFFFF
                                                                        : $urandom();
                pick = $urandom_range(2);
                off  = (pick == 0) ? 0 : (pick == 1) ? 65535 : $urandom_range(65535);
                wmax = 65535;
                run_len = $urandom_range(1, 24);
            end else begin
                // weight_sum near a run's sum so counts add up to about P
                pc      = $urandom_range(1, 4096);
                run_len = $urandom_range(1, 24);
                pick    = $urandom_range(2);
                wmax    = (pick == 0) ? 255 : (pick == 1) ? 4095 : 65535;
                ws      = (run_len * wmax) / 2 + $urandom_range(0, 3);
                off     = $urandom_range(65535);
            end
            program_regs(pc, ws & 28'hFFFFFFF, off);

            calm = (phase == 4);
            if (phase == 2)
                rx_hold_req = 400;
            n_items = $urandom_range(60, 140);
            run_pos = 0;
            for (int i = 0; i < n_items; i++)
            begin
                pick = $urandom_range(99);
                if (pick < 5)
                    w = '0;
                else if (pick < 10)
                    w = '1;
                else
                    w = srr_pkg::WEIGHT_W'($urandom_range(0, wmax));
                last = (run_pos == run_len - 1) || ($urandom_range(99) < 3);
                run_pos = last ? 0 : run_pos + 1;
                if (phase == 6 && i == n_items / 2)
                    settle(0);
                send_weight(w, last);
            end
            sent += n_items;
            calm = 1'b0;
            settle(SETTLE_CYCLES);
            phase++;
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("** systematic_resampling_replication: PASSED **");
        else
            $display("** systematic_resampling_replication: FAILED **");
        $finish;
    end

endmodule
